/* src/assert_macros.svh */
// assertion helpers for the rtl files, included by led_pattern_sequencer
// each macro expects aclk and aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("invariant violated");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication violated");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

/* src/lps_pkg.sv */
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types, register codes and pattern tables of the LED sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

    localparam int unsigned NUM_PATTERNS = 13;

    // phase codes
    localparam logic [1:0] PH_RUN      = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_HOLD     = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SLOW     = 2'd0;
    localparam logic [1:0] REG_MEDIUM   = 2'd1;
    localparam logic [1:0] REG_NORMAL   = 2'd2;
    localparam logic [1:0] REG_DEBOUNCE = 2'd3;

    localparam logic [7:0] RST_SLOW     = 8'd5;
    localparam logic [7:0] RST_MEDIUM   = 8'd3;
    localparam logic [7:0] RST_NORMAL   = 8'd4;
    localparam logic [7:0] RST_DEBOUNCE = 8'd2;

    typedef struct packed {
        logic [7:0] ticks_slow;
        logic [7:0] ticks_medium;
        logic [7:0] ticks_normal;
        logic [7:0] ticks_debounce;
    } cfg_t;

    // number of frames in each pattern
    function automatic logic [7:0] frame_count(input logic [3:0] pat);
        logic [7:0] n;
        case (pat)
            4'd0:    n = 8'd2;
            4'd1:    n = 8'd14;
            4'd2:    n = 8'd8;
            4'd3:    n = 8'd16;
            4'd4:    n = 8'd80;
            4'd5:    n = 8'd8;
            4'd6:    n = 8'd160;
            4'd7:    n = 8'd160;
            4'd8:    n = 8'd8;
            4'd9:    n = 8'd16;
            4'd10:   n = 8'd120;
            4'd11:   n = 8'd80;
            4'd12:   n = 8'd80;
            default: n = 8'd1;
        endcase
        return n;
    endfunction

    // length minus one, with zero treated as one
    function automatic logic [7:0] len_m1(input logic [7:0] t);
        return (t == 8'd0) ? 8'd0 : t - 8'd1;
    endfunction

endpackage

`default_nettype wire

/* src/lps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lps_cfg_regs
// Frame and debounce tick count registers behind the write channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_cfg_regs (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_en,
    input  wire logic [1:0]    wr_index,
    input  wire logic [7:0]    wr_data,
    output lps_pkg::cfg_t      cfg
);

    lps_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_slow     <= lps_pkg::RST_SLOW;
            cfg_reg.ticks_medium   <= lps_pkg::RST_MEDIUM;
            cfg_reg.ticks_normal   <= lps_pkg::RST_NORMAL;
            cfg_reg.ticks_debounce <= lps_pkg::RST_DEBOUNCE;
        end else if (wr_en) begin
            unique case (wr_index)
                lps_pkg::REG_SLOW:     cfg_reg.ticks_slow     <= wr_data;
                lps_pkg::REG_MEDIUM:   cfg_reg.ticks_medium   <= wr_data;
                lps_pkg::REG_NORMAL:   cfg_reg.ticks_normal   <= wr_data;
                lps_pkg::REG_DEBOUNCE: cfg_reg.ticks_debounce <= wr_data;
                default:               cfg_reg.ticks_slow     <= cfg_reg.ticks_slow;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* src/lps_frame_gen.sv */
// ----------------------------------------------------------------------------
// lps_frame_gen
// Forms the LED value of one frame from pattern, frame number and prior LEDs.
// ----------------------------------------------------------------------------
`default_nettype none

module lps_frame_gen (
    input  wire logic [3:0] pattern,
    input  wire logic [7:0] frame,
    input  wire logic [7:0] base,
    output logic [7:0]      led
);

    logic [15:0] w;
    logic [15:0] b;
    logic [2:0]  j;
    logic [1:0]  k2;
    logic [15:0] mask_in;
    logic [15:0] mask_out;
    logic [3:0]  dsum;
    logic [3:0]  r3;
    logic [3:0]  k12;
    logic [2:0]  i10;
    logic [2:0]  i11;

    always_comb begin
        b  = {8'd0, base};
        j  = frame[2:0];
        k2 = frame[1:0];
        mask_in  = (16'd16 << k2) | (16'd8 >> k2);
        mask_out = (16'd128 >> k2) | (16'd1 << k2);

        // frame mod 12 from base-4 digit sum of frame >> 2
        dsum = {2'd0, frame[3:2]} + {2'd0, frame[5:4]} + {2'd0, frame[7:6]};
        if (dsum >= 4'd9) begin
            r3 = dsum - 4'd9;
        end else if (dsum >= 4'd6) begin
            r3 = dsum - 4'd6;
        end else if (dsum >= 4'd3) begin
            r3 = dsum - 4'd3;
        end else begin
            r3 = dsum;
        end
        k12 = {r3[1:0], frame[1:0]};
        i10 = (k12 < 4'd4) ? 3'(k12 + 4'd4) : 3'(k12 - 4'd4);

        // even positions walking up, then odd positions walking down
        i11 = j[2] ? (3'd7 - {j[1:0], 1'b0}) : {j[1:0], 1'b0};

        case (pattern)
            4'd0:  w = (frame == 8'd0) ? 16'h00F0 : 16'h000F;
            4'd1:  w = (frame < 8'd7) ? (16'h00C0 >> j) : (16'd3 << 3'(j + 3'd1));
            4'd2:  w = 16'h01C0 >> j;
            4'd3, 4'd9: begin
                case (frame[3:2])
                    2'd0:    w = b | mask_in;
                    2'd1:    w = b & ~mask_in;
                    2'd2:    w = b | mask_out;
                    default: w = b & ~mask_out;
                endcase
            end
            4'd4:  w = b ^ (16'd128 >> j);
            4'd5:  w = (16'd192 >> j) | (16'd3 << j);
            4'd6:  w = b ^ (frame[3] ? (16'd128 >> j) : (16'd1 << j));
            4'd7:  w = b ^ (frame[3] ? (16'd1 << j) : (16'd128 >> j));
            4'd8:  w = b | (16'd128 >> j);
            4'd10: w = b ^ ((16'd1 << i10) | (16'd128 >> i10));
            4'd11: w = b ^ (16'd1 << i11);
            4'd12: w = b ^ (16'd1 << j);
            default: w = 16'd0;
        endcase
        led = w[7:0];
    end

endmodule

`default_nettype wire

/* src/led_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// led_pattern_sequencer
// Tick-driven LED pattern sequencer with button debounce and pattern select.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one beat per 50 ms tick, s_tdata[0] is the button level.
//   m_ channel: one beat per input beat carrying the LED drive, the selected
//   pattern and the waiting-for-release flag.
//   cfg channel: writes one of the four tick count registers; always ready,
//   write only while no tick is in flight.
//   Path: a tick passes the input register, then the result register, which drives m_.
//   Throughput: one tick per cycle while m_ does not stall, set by the state update
//   between the input register and the result register.
//   Reset (aresetn low, synchronous): pattern 0, frame 0, LEDs off, running,
//   tick counts back to 5/3/4/2, both beat registers empty.
//   A stalled m_ side holds its beat; the input register still takes one
//   more tick, then s_tready drops until the result beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module led_pattern_sequencer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] button_pressed, [7:1] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] led_value, [11:8] pattern_number,
                                        // [12] waiting_release, [15:13] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    `include "assert_macros.svh"

    lps_pkg::cfg_t cfg;

    logic       in_valid_reg;
    logic       in_btn_reg;
    logic       out_valid_reg;
    logic [7:0] out_led_reg;
    logic [3:0] out_pat_reg;
    logic       out_wait_reg;

    logic [3:0] pattern_reg, pattern_next;
    logic [7:0] frame_reg, frame_next;
    logic [7:0] ticks_reg, ticks_next;
    logic [7:0] led_reg, led_next;
    logic [1:0] phase_reg, phase_next;

    logic       advance;
    logic       do_begin;
    logic       use_press;
    logic [3:0] pat_inc;
    logic [3:0] gen_pat;
    logic [7:0] gen_frame;
    logic [7:0] gen_base;
    logic [7:0] gen_led;
    logic [7:0] gen_len;
    logic       frames_done;

    assign cfg_ready = 1'b1;

    lps_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_btn_reg <= s_tdata[0];
        end
    end

    assign pat_inc = (pattern_reg + 4'd1 >= 4'(lps_pkg::NUM_PATTERNS))
                   ? 4'(pattern_reg + 4'd1 - 4'(lps_pkg::NUM_PATTERNS))
                   : pattern_reg + 4'd1;

    assign frames_done = frame_reg >= lps_pkg::frame_count(pattern_reg);

    // which frame (if any) begins on this tick
    always_comb begin
        do_begin  = 1'b0;
        use_press = 1'b0;
        gen_pat   = pattern_reg;
        gen_frame = frame_reg;
        if (ticks_reg == 8'd0) begin
            unique case (phase_reg) inside
                lps_pkg::PH_DEBOUNCE, lps_pkg::PH_HOLD: begin
                    if (!in_btn_reg) begin
                        do_begin  = 1'b1;
                        gen_pat   = pat_inc;
                        gen_frame = 8'd0;
                    end
                end
                default: begin
                    if (frames_done) begin
                        if (!in_btn_reg) begin
                            do_begin  = 1'b1;
                            gen_frame = 8'd0;
                        end
                    end else begin
                        do_begin  = 1'b1;
                        use_press = in_btn_reg;
                    end
                end
            endcase
        end
        gen_base = (gen_frame == 8'd0) ? 8'd0 : led_reg;
    end

    lps_frame_gen u_frame (
        .pattern (gen_pat),
        .frame   (gen_frame),
        .base    (gen_base),
        .led     (gen_led)
    );

    always_comb begin
        unique case (gen_pat) inside
            4'd0:             gen_len = cfg.ticks_slow;
            4'd1, 4'd2, 4'd8: gen_len = cfg.ticks_medium;
            default:          gen_len = cfg.ticks_normal;
        endcase
    end

    // state update for one tick
    always_comb begin
        pattern_next = pattern_reg;
        frame_next   = frame_reg;
        ticks_next   = ticks_reg;
        led_next     = led_reg;
        phase_next   = phase_reg;
        if (ticks_reg != 8'd0) begin
            ticks_next = ticks_reg - 8'd1;
        end else if (do_begin) begin
            pattern_next = gen_pat;
            phase_next   = lps_pkg::PH_RUN;
            led_next     = gen_led;
            // a press in pattern 0 keeps only the first fill
            if (use_press && gen_pat == 4'd0) begin
                led_next = (gen_frame == 8'd0) ? 8'h80 : 8'h01;
            end
            if (use_press) begin
                phase_next = lps_pkg::PH_DEBOUNCE;
                ticks_next = lps_pkg::len_m1(cfg.ticks_debounce);
            end else begin
                frame_next = gen_frame + 8'd1;
                ticks_next = lps_pkg::len_m1(gen_len);
            end
        end else begin
            // button held: run moves to debounce, debounce moves to hold, hold clears the leds
            unique case (phase_reg)
                lps_pkg::PH_DEBOUNCE: phase_next = lps_pkg::PH_HOLD;
                lps_pkg::PH_HOLD:     led_next   = 8'd0;
                default:              phase_next = lps_pkg::PH_DEBOUNCE;
            endcase
            ticks_next = lps_pkg::len_m1(cfg.ticks_debounce);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= 4'd0;
            frame_reg   <= 8'd0;
            ticks_reg   <= 8'd0;
            led_reg     <= 8'd0;
            phase_reg   <= lps_pkg::PH_RUN;
        end else if (advance) begin
            pattern_reg <= pattern_next;
            frame_reg   <= frame_next;
            ticks_reg   <= ticks_next;
            led_reg     <= led_next;
            phase_reg   <= phase_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_led_reg  <= led_next;
            out_pat_reg  <= pattern_next;
            out_wait_reg <= (phase_next != lps_pkg::PH_RUN);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_wait_reg, out_pat_reg, out_led_reg};

    `ASSERT_ALWAYS(a_pattern_range, pattern_reg < 4'(lps_pkg::NUM_PATTERNS))
    `ASSERT_ALWAYS(a_phase_code, phase_reg != 2'd3)
    `ASSERT_IMPL(a_stall_blocks_input, in_valid_reg && !advance, !s_tready)
    `ASSERT_NEXT(a_advance_fills_output, advance, out_valid_reg)

endmodule

`default_nettype wire
